FILE: rtl/ivrt_pkg.sv
package ivrt_pkg;

  // defaults
  localparam int unsigned ROUTE_COUNT_DEF = 16;
  localparam logic [7:0] VECTOR_BASE_RST = 8'd48;

  // operation codes
  localparam logic [1:0] MODE_REGISTER = 2'd0;
  localparam logic [1:0] MODE_CLEAR    = 2'd1;
  localparam logic [1:0] MODE_DISPATCH = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  // one route as stored in the table memory
  typedef struct packed {
    logic [7:0]  device;
    logic [7:0]  task_id;
    logic        owned;
    logic [15:0] notify;
    logic [31:0] badge;
  } route_t;

  // one request word
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  device_index;
    logic [7:0]  task_id;
    logic [15:0] notify_index;
    logic [31:0] badge;
    logic        device_has_msi;
    logic        device_has_address;
    logic        program_ok;
    logic [7:0]  vector_in;
  } req_t;

  // one result word
  typedef struct packed {
    logic [7:0]  vector_out;
    logic        is_ours;
    logic        notify_valid;
    logic [15:0] notify_index;
    logic [31:0] badge;
  } res_t;

endpackage

FILE: rtl/ivrt_route_mem.sv
module ivrt_route_mem #(
  parameter int unsigned DEPTH  = ivrt_pkg::ROUTE_COUNT_DEF,
  parameter int unsigned ADDR_W = 4
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output ivrt_pkg::route_t      rd_data,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  ivrt_pkg::route_t      wr_data
);

  ivrt_pkg::route_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/ivrt_seq.sv
module ivrt_seq #(
  parameter int unsigned ROUTE_COUNT = ivrt_pkg::ROUTE_COUNT_DEF,
  parameter int unsigned IDX_W       = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            vector_base,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ivrt_pkg::req_t        req,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ivrt_pkg::res_t        res,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  ivrt_pkg::route_t      rd_data,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output ivrt_pkg::route_t      wr_data
);

  localparam int unsigned CNT_W = $clog2(ROUTE_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ROUTE_COUNT);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_REG_WALK = 3'd1;
  localparam logic [2:0] S_CLR_WALK = 3'd2;
  localparam logic [2:0] S_DISP_RD  = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0]             state;
  ivrt_pkg::req_t         item;
  logic [CNT_W-1:0]       cnt;
  logic                   rd_pend;
  logic [IDX_W-1:0]       rd_idx;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic [ROUTE_COUNT-1:0] live;

  logic [IDX_W-1:0] idx_now;
  logic             walk_issue;
  logic [8:0]       range_lo;
  logic [8:0]       range_hi;
  logic [8:0]       vec_ext;
  logic             in_range;
  logic [7:0]       vec_diff;
  logic [IDX_W-1:0] disp_idx;
  logic             disp_issue;
  logic             reg_hit;
  logic             reg_end;
  logic             alloc_wr;
  logic             clr_hit;
  ivrt_pkg::route_t new_route;
  ivrt_pkg::route_t cleared_route;
  ivrt_pkg::res_t   res_init;

  function automatic logic [7:0] vec_of(input logic [7:0] b, input logic [IDX_W-1:0] i);
    return b + 8'(i);
  endfunction

  // walk issue: one entry read per cycle
  assign idx_now    = cnt[IDX_W-1:0];
  assign walk_issue = ((state == S_REG_WALK) || (state == S_CLR_WALK)) && (cnt < CNT_END);

  // dispatch range check against the unwrapped table range
  assign range_lo   = {1'b0, vector_base};
  assign range_hi   = range_lo + 9'(ROUTE_COUNT);
  assign vec_ext    = {1'b0, req.vector_in};
  assign in_range   = (vec_ext >= range_lo) && (vec_ext < range_hi);
  assign vec_diff   = req.vector_in - vector_base;
  assign disp_idx   = vec_diff[IDX_W-1:0];
  assign disp_issue = (state == S_IDLE) && in_valid &&
                      (req.mode == ivrt_pkg::MODE_DISPATCH) && in_range;

  // entry checks on returned read data
  assign reg_hit  = (state == S_REG_WALK) && rd_pend && live[rd_idx] &&
                    (rd_data.device == item.device_index);
  assign reg_end  = (state == S_REG_WALK) && !reg_hit && (cnt == CNT_END) && !rd_pend;
  assign alloc_wr = reg_end && free_found && item.program_ok;
  assign clr_hit  = (state == S_CLR_WALK) && rd_pend && live[rd_idx] && rd_data.owned &&
                    (rd_data.task_id == item.task_id);

  // write data
  always_comb begin
    new_route.device  = item.device_index;
    new_route.task_id = item.task_id;
    new_route.owned   = 1'b1;
    new_route.notify  = item.notify_index;
    new_route.badge   = item.badge;
    cleared_route       = rd_data;
    cleared_route.owned = 1'b0;
  end

  // result word at acceptance, with the dispatch range flag
  always_comb begin
    res_init         = '0;
    res_init.is_ours = (req.mode == ivrt_pkg::MODE_DISPATCH) && in_range;
  end

  // memory port control
  assign rd_en   = walk_issue || disp_issue;
  assign rd_addr = disp_issue ? disp_idx : idx_now;
  assign wr_en   = reg_hit || alloc_wr || clr_hit;
  assign wr_addr = (reg_hit || clr_hit) ? rd_idx : free_idx;
  assign wr_data = clr_hit ? cleared_route : new_route;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
      live    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item       <= req;
            cnt        <= '0;
            rd_pend    <= disp_issue;
            rd_idx     <= disp_idx;
            free_found <= 1'b0;
            res        <= res_init;
            case (req.mode)
              ivrt_pkg::MODE_REGISTER: begin
                if (req.device_has_msi && req.device_has_address) begin
                  state <= S_REG_WALK;
                end else begin
                  state <= S_DONE;
                end
              end
              ivrt_pkg::MODE_CLEAR: begin
                state <= S_CLR_WALK;
              end
              ivrt_pkg::MODE_DISPATCH: begin
                if (in_range) begin
                  state <= S_DISP_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_REG_WALK: begin
          rd_pend <= walk_issue;
          if (walk_issue) begin
            cnt    <= cnt + 1'b1;
            rd_idx <= idx_now;
            if (!live[idx_now] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= idx_now;
            end
          end
          if (reg_hit) begin
            state          <= S_DONE;
            res.vector_out <= item.program_ok ? vec_of(vector_base, rd_idx) : 8'd0;
          end else if (reg_end) begin
            state <= S_DONE;
            if (alloc_wr) begin
              live[free_idx] <= 1'b1;
              res.vector_out <= vec_of(vector_base, free_idx);
            end
          end
        end
        S_CLR_WALK: begin
          rd_pend <= walk_issue;
          if (walk_issue) begin
            cnt    <= cnt + 1'b1;
            rd_idx <= idx_now;
          end
          if ((cnt == CNT_END) && !rd_pend) begin
            state <= S_DONE;
          end
        end
        S_DISP_RD: begin
          rd_pend <= 1'b0;
          if (live[rd_idx] && rd_data.owned) begin
            res.notify_valid <= 1'b1;
            res.notify_index <= rd_data.notify;
            res.badge        <= rd_data.badge;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/interrupt_vector_route_table.sv
// Interrupt route table: entry i of ROUTE_COUNT owns vector cfg_data + i. The base
// must be written through the configuration channel only while the block is idle;
// the block itself does not enforce this. One request word is worked on at a time.
// Route data sits in a single-port-read memory, so register and clear walk the
// entries one per cycle (register stops early on an already routed device);
// dispatch is one memory read; a rejected register or an out-of-range dispatch
// skips the memory. A result register on the output lets the next request word be
// taken while the previous result is still stalled.
module interrupt_vector_route_table_core #(
  parameter int unsigned ROUTE_COUNT = ivrt_pkg::ROUTE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  device_index,
  input  logic [7:0]  task_id,
  input  logic [15:0] notify_index_in,
  input  logic [31:0] badge_in,
  input  logic        device_has_msi,
  input  logic        device_has_address,
  input  logic        program_ok,
  input  logic [7:0]  vector_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  vector_out,
  output logic        is_ours,
  output logic        notify_valid,
  output logic [15:0] notify_index_out,
  output logic [31:0] badge_out
);

  localparam int unsigned IDX_W = (ROUTE_COUNT > 1) ? $clog2(ROUTE_COUNT) : 1;

  logic [7:0]       vector_base;
  ivrt_pkg::req_t   req;
  ivrt_pkg::res_t   res;
  ivrt_pkg::res_t   out_word;
  logic             seq_ready;
  logic             res_valid;
  logic             res_ready;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  ivrt_pkg::route_t rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  ivrt_pkg::route_t wr_data;

  // base register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_base <= ivrt_pkg::VECTOR_BASE_RST;
    end else if (cfg_valid) begin
      vector_base <= cfg_data;
    end
  end

  // request word
  always_comb begin
    req.mode               = mode;
    req.device_index       = device_index;
    req.task_id            = task_id;
    req.notify_index       = notify_index_in;
    req.badge              = badge_in;
    req.device_has_msi     = device_has_msi;
    req.device_has_address = device_has_address;
    req.program_ok         = program_ok;
    req.vector_in          = vector_in;
  end

  assign in_stall = !seq_ready;

  ivrt_seq #(
    .ROUTE_COUNT (ROUTE_COUNT),
    .IDX_W       (IDX_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .vector_base (vector_base),
    .in_valid    (in_valid),
    .in_ready    (seq_ready),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  ivrt_route_mem #(
    .DEPTH  (ROUTE_COUNT),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // output register
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign vector_out       = out_word.vector_out;
  assign is_ours          = out_word.is_ours;
  assign notify_valid     = out_word.notify_valid;
  assign notify_index_out = out_word.notify_index;
  assign badge_out        = out_word.badge;

endmodule

FILE: tb/sv/tb_interrupt_vector_route_table_core.sv
module tb_interrupt_vector_route_table_core;

  localparam int ROUTES = ivrt_pkg::ROUTE_COUNT_DEF;
  localparam int DRAIN_CYCLES = 2 * ROUTES + 8;
  localparam int SHOWN_LIMIT = 10;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [7:0]  device_index;
  logic [7:0]  task_id;
  logic [15:0] notify_index_in;
  logic [31:0] badge_in;
  logic        device_has_msi;
  logic        device_has_address;
  logic        program_ok;
  logic [7:0]  vector_in;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  vector_out;
  logic        is_ours;
  logic        notify_valid;
  logic [15:0] notify_index_out;
  logic [31:0] badge_out;

  // shadow copy of the route table and base
  logic        route_live   [ROUTES];
  logic [7:0]  route_device [ROUTES];
  logic [7:0]  route_owner  [ROUTES];
  logic        route_owned  [ROUTES];
  logic [15:0] route_notify [ROUTES];
  logic [31:0] route_badge  [ROUTES];
  logic [7:0]  route_base;

  ivrt_pkg::res_t expected_results[$];
  int   fail_count;
  int   shown_count;
  int   sender_idle_pct;
  int   stall_pct;
  int   hold_cycles;

  interrupt_vector_route_table_core dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .mode               (mode),
    .device_index       (device_index),
    .task_id            (task_id),
    .notify_index_in    (notify_index_in),
    .badge_in           (badge_in),
    .device_has_msi     (device_has_msi),
    .device_has_address (device_has_address),
    .program_ok         (program_ok),
    .vector_in          (vector_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .vector_out         (vector_out),
    .is_ours            (is_ours),
    .notify_valid       (notify_valid),
    .notify_index_out   (notify_index_out),
    .badge_out          (badge_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop
  initial begin
    #1000000;
    $display("tb_interrupt_vector_route_table_core: done, errors");
    $finish;
  end

  // expected result word for one request; updates the shadow table
  function automatic ivrt_pkg::res_t route_outcome(input ivrt_pkg::req_t rq);
    ivrt_pkg::res_t r;
    int   hit;
    int   slot;
    r = '0;
    hit = -1;
    slot = -1;
    case (rq.mode)
      ivrt_pkg::MODE_REGISTER: begin
        if (rq.device_has_msi && rq.device_has_address) begin
          for (int i = 0; i < ROUTES; i++)
            if (hit < 0 && route_live[i] && route_device[i] == rq.device_index) hit = i;
          if (hit < 0) begin
            for (int i = 0; i < ROUTES; i++)
              if (slot < 0 && !route_live[i]) slot = i;
            // a failed allocation leaves the entry free
            if (slot >= 0) begin
              route_device[slot] = rq.device_index;
              route_live[slot] = rq.program_ok;
              hit = slot;
            end
          end
          if (hit >= 0) begin
            route_owner[hit] = rq.task_id;
            route_owned[hit] = 1'b1;
            route_notify[hit] = rq.notify_index;
            route_badge[hit] = rq.badge;
            if (rq.program_ok) r.vector_out = 8'(int'(route_base) + hit);
          end
        end
      end
      ivrt_pkg::MODE_CLEAR: begin
        for (int i = 0; i < ROUTES; i++)
          if (route_live[i] && route_owned[i] && route_owner[i] == rq.task_id)
            route_owned[i] = 1'b0;
      end
      ivrt_pkg::MODE_DISPATCH: begin
        // range check on the unwrapped vector
        if (int'(rq.vector_in) >= int'(route_base) &&
            int'(rq.vector_in) < int'(route_base) + ROUTES) begin
          hit = int'(rq.vector_in) - int'(route_base);
          r.is_ours = 1'b1;
          if (route_live[hit] && route_owned[hit]) begin
            r.notify_valid = 1'b1;
            r.notify_index = route_notify[hit];
            r.badge = route_badge[hit];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic ivrt_pkg::req_t make_req(input logic [1:0] m, input logic [7:0] dev,
                                              input logic [7:0] owner,
                                              input logic [15:0] notify,
                                              input logic [31:0] badge, input logic msi,
                                              input logic addr, input logic ok,
                                              input logic [7:0] vec);
    ivrt_pkg::req_t rq;
    rq.mode = m;
    rq.device_index = dev;
    rq.task_id = owner;
    rq.notify_index = notify;
    rq.badge = badge;
    rq.device_has_msi = msi;
    rq.device_has_address = addr;
    rq.program_ok = ok;
    rq.vector_in = vec;
    return rq;
  endfunction

  // mostly a small device and task pool so updates, clears and hits happen
  function automatic ivrt_pkg::req_t random_request();
    ivrt_pkg::req_t rq;
    int   pick;
    rq.mode = 2'($urandom_range(3));
    rq.device_index = ($urandom_range(99) < 60) ? 8'($urandom_range(23))
                                                : 8'($urandom_range(255));
    rq.task_id = ($urandom_range(99) < 80) ? 8'($urandom_range(7))
                                           : 8'($urandom_range(255));
    rq.notify_index = 16'($urandom);
    rq.badge = $urandom;
    rq.device_has_msi = ($urandom_range(99) < 90);
    rq.device_has_address = ($urandom_range(99) < 90);
    rq.program_ok = ($urandom_range(99) < 85);
    rq.vector_in = ($urandom_range(99) < 75) ? 8'(route_base + $urandom_range(ROUTES - 1))
                                             : 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 40) rq.mode = ivrt_pkg::MODE_REGISTER;
    else if (pick < 52) rq.mode = ivrt_pkg::MODE_CLEAR;
    else if (pick < 96) rq.mode = ivrt_pkg::MODE_DISPATCH;
    else rq.mode = ivrt_pkg::MODE_UNUSED;
    return rq;
  endfunction

  // send one request word, predict on acceptance
  task automatic send_request(input ivrt_pkg::req_t rq);
    logic took;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= rq.mode;
    device_index <= rq.device_index;
    task_id <= rq.task_id;
    notify_index_in <= rq.notify_index;
    badge_in <= rq.badge;
    device_has_msi <= rq.device_has_msi;
    device_has_address <= rq.device_has_address;
    program_ok <= rq.program_ok;
    vector_in <= rq.vector_in;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    expected_results.push_back(route_outcome(rq));
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_vector_base(input logic [7:0] base);
    logic took;
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= base;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    route_base = base;
  endtask

  // receiver stall: long hold-off first, else random
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // result checker, sampled mid-cycle
  always @(negedge clk) begin : check_result
    ivrt_pkg::res_t seen;
    ivrt_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      seen.vector_out = vector_out;
      seen.is_ours = is_ours;
      seen.notify_valid = notify_valid;
      seen.notify_index = notify_index_out;
      seen.badge = badge_out;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (shown_count < SHOWN_LIMIT) begin
          shown_count++;
          $display("unexpected result word: vec=%0d ours=%0b nv=%0b idx=%h badge=%h",
                   seen.vector_out, seen.is_ours, seen.notify_valid,
                   seen.notify_index, seen.badge);
        end
      end else begin
        want = expected_results.pop_front();
        if (seen.vector_out !== want.vector_out || seen.is_ours !== want.is_ours ||
            seen.notify_valid !== want.notify_valid ||
            seen.notify_index !== want.notify_index || seen.badge !== want.badge) begin
          fail_count++;
          if (shown_count < SHOWN_LIMIT) begin
            shown_count++;
            $display("mismatch: want vec=%0d ours=%0b nv=%0b idx=%h badge=%h",
                     want.vector_out, want.is_ours, want.notify_valid,
                     want.notify_index, want.badge);
            $display("          got  vec=%0d ours=%0b nv=%0b idx=%h badge=%h",
                     seen.vector_out, seen.is_ours, seen.notify_valid,
                     seen.notify_index, seen.badge);
          end
        end
      end
    end
  end

  // register: first routes, rejects, failed programming, updates
  task automatic test_register_cases();
    send_request(make_req(ivrt_pkg::MODE_REGISTER, 8'd0, 8'd0, 16'h0000, 32'h0,
                          1'b1, 1'b1, 1'b1, 8'd0));
    send_request(make_req(ivrt_pkg::MODE_REGISTER, 8'd255, 8'd255, 16'hffff, 32'hffff_ffff,
                          1'b1, 1'b1, 1'b1, 8'd255));
    send_request(make_req(ivrt_pkg::MODE_REGISTER, 8'd7, 8'd2, 16'h0101, 32'h1,
                          1'b0, 1'b1, 1'b1, 8'd48));
    send_request(make_req(ivrt_pkg::MODE_REGISTER, 8'd7, 8'd2, 16'h0101, 32'h1,
                          1'b1, 1'b0, 1'b1, 8'd48));
    send_request(make_req(ivrt_pkg::MODE_REGISTER, 8'd9, 8'd2, 16'h0202, 32'h2,
                          1'b1, 1'b1, 1'b0, 8'd48));
    send_request(make_req(ivrt_pkg::MODE_REGISTER, 8'd10, 8'd2, 16'h0303, 32'h3,
                          1'b1, 1'b1, 1'b1, 8'd48));
    send_request(make_req(ivrt_pkg::MODE_REGISTER, 8'd0, 8'd3, 16'h1234, 32'hdead_beef,
                          1'b1, 1'b1, 1'b0, 8'd0));
    send_request(make_req(ivrt_pkg::MODE_REGISTER, 8'd255, 8'd255, 16'hfffe, 32'hffff_fffe,
                          1'b1, 1'b1, 1'b1, 8'd0));
  endtask

  // dispatch range edges, clear of a task, re-registering an ownerless route
  task automatic test_clear_and_dispatch();
    send_request(make_req(ivrt_pkg::MODE_DISPATCH, 8'd0, 8'd0, 16'h0, 32'h0,
                          1'b0, 1'b0, 1'b0, 8'd48));
    send_request(make_req(ivrt_pkg::MODE_DISPATCH, 8'd0, 8'd0, 16'h0, 32'h0,
                          1'b0, 1'b0, 1'b0, 8'd49));
    send_request(make_req(ivrt_pkg::MODE_DISPATCH, 8'd0, 8'd0, 16'h0, 32'h0,
                          1'b0, 1'b0, 1'b0, 8'd47));
    send_request(make_req(ivrt_pkg::MODE_DISPATCH, 8'd0, 8'd0, 16'h0, 32'h0,
                          1'b0, 1'b0, 1'b0, 8'd64));
    send_request(make_req(ivrt_pkg::MODE_DISPATCH, 8'd0, 8'd0, 16'h0, 32'h0,
                          1'b0, 1'b0, 1'b0, 8'd63));
    send_request(make_req(ivrt_pkg::MODE_DISPATCH, 8'd0, 8'd0, 16'h0, 32'h0,
                          1'b0, 1'b0, 1'b0, 8'd0));
    send_request(make_req(ivrt_pkg::MODE_DISPATCH, 8'd0, 8'd0, 16'h0, 32'h0,
                          1'b0, 1'b0, 1'b0, 8'd255));
    send_request(make_req(ivrt_pkg::MODE_CLEAR, 8'd0, 8'd3, 16'h0, 32'h0,
                          1'b0, 1'b0, 1'b0, 8'd0));
    send_request(make_req(ivrt_pkg::MODE_DISPATCH, 8'd0, 8'd0, 16'h0, 32'h0,
                          1'b0, 1'b0, 1'b0, 8'd48));
    send_request(make_req(ivrt_pkg::MODE_CLEAR, 8'd0, 8'd255, 16'h0, 32'h0,
                          1'b1, 1'b1, 1'b1, 8'd0));
    send_request(make_req(ivrt_pkg::MODE_DISPATCH, 8'd0, 8'd0, 16'h0, 32'h0,
                          1'b0, 1'b0, 1'b0, 8'd49));
    send_request(make_req(ivrt_pkg::MODE_REGISTER, 8'd0, 8'd1, 16'h4321, 32'h0bad_f00d,
                          1'b1, 1'b1, 1'b1, 8'd0));
    send_request(make_req(ivrt_pkg::MODE_DISPATCH, 8'd0, 8'd0, 16'h0, 32'h0,
                          1'b0, 1'b0, 1'b0, 8'd48));
    // unused mode with every field set
    send_request(make_req(ivrt_pkg::MODE_UNUSED, 8'hff, 8'hff, 16'hffff, 32'hffff_ffff,
                          1'b1, 1'b1, 1'b1, 8'd48));
  endtask

  task automatic test_random_mix(input int count, input int send_pct, input int rx_pct);
    sender_idle_pct = send_pct;
    stall_pct = rx_pct;
    repeat (count) send_request(random_request());
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    repeat (30) send_request(random_request());
  endtask

  initial begin
    fail_count = 0;
    shown_count = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    route_base = ivrt_pkg::VECTOR_BASE_RST;
    for (int i = 0; i < ROUTES; i++) begin
      route_live[i] = 1'b0;
      route_device[i] = '0;
      route_owner[i] = '0;
      route_owned[i] = 1'b0;
      route_notify[i] = '0;
      route_badge[i] = '0;
    end
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    mode <= ivrt_pkg::MODE_REGISTER;
    device_index <= '0;
    task_id <= '0;
    notify_index_in <= '0;
    badge_in <= '0;
    device_has_msi <= 1'b0;
    device_has_address <= 1'b0;
    program_ok <= 1'b0;
    vector_in <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_cases();
    test_clear_and_dispatch();
    set_vector_base(8'd240);
    test_random_mix(200, 35, 84);
    set_vector_base(8'd1);
    test_random_mix(200, 84, 35);
    set_vector_base(8'd102);
    test_random_mix(200, 0, 0);
    set_vector_base(ivrt_pkg::VECTOR_BASE_RST);
    test_backpressure();

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_interrupt_vector_route_table_core: done, clean");
    end else begin
      $display("tb_interrupt_vector_route_table_core: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ivrt_pkg.sv
rtl/ivrt_route_mem.sv
rtl/ivrt_seq.sv
rtl/interrupt_vector_route_table.sv
tb/sv/tb_interrupt_vector_route_table_core.sv
